// ----- rtl/core/kvse_pkg.sv -----
// Shared types, constants and helpers for the key/value string extractor.
package kvse_pkg;

	localparam int KEY_MAX_DEF   = 32;
	localparam int DELIM_MAX_DEF = 4;
	localparam int QDEPTH        = 2;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DICT = 1'b1;

	localparam logic KIND_VALUE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_NULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [2:0] REG_ISEP     = 3'd0;
	localparam logic [2:0] REG_ISEP_LEN = 3'd1;
	localparam logic [2:0] REG_PSEP     = 3'd2;
	localparam logic [2:0] REG_PSEP_LEN = 3'd3;

	typedef enum logic [3:0] {
		PH_PREFIX = 4'b0001,
		PH_SKIP   = 4'b0010,
		PH_VALUE  = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// results of one item: bytes src[a-1] for a = hi down to lo, then optional status
	typedef struct packed {
		logic [31:0] src;
		logic [2:0]  hi;
		logic [2:0]  lo;
		logic        has_status;
		logic [1:0]  status;
	} res_t;

	function automatic logic [7:0] byte_at(input logic [31:0] w, input logic [1:0] i);
		return w[8*i +: 8];
	endfunction

endpackage

// ----- rtl/core/kvse_front.sv -----
// Front part: key load, dictionary scan state and result bundle build.
module kvse_front #(
	parameter int KEY_MAX   = kvse_pkg::KEY_MAX_DEF,
	parameter int DELIM_MAX = kvse_pkg::DELIM_MAX_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic           opcode,
	input  logic [7:0]     data_byte,
	input  logic           is_final,
	input  logic           no_byte,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	output logic           push,
	output kvse_pkg::res_t push_data
);
	import kvse_pkg::*;

	localparam int POS_CAP = KEY_MAX + 3 * DELIM_MAX;
	localparam int PW      = $clog2(POS_CAP + 2);
	localparam int KLW     = $clog2(KEY_MAX + 1);
	localparam int KIW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CAP     = (DELIM_MAX < 4) ? DELIM_MAX : 4;

	logic [31:0]    isep_q, psep_q;
	logic [2:0]     isep_len_q, psep_len_q;
	logic [7:0]     key_mem_q [KEY_MAX];
	logic [KLW-1:0] key_len_q;
	logic           key_ovf_q, key_closed_q;
	logic [23:0]    recent_q;
	logic [PW-1:0]  pos_q;
	phase_t         phase_q;
	logic [1:0]     held_q;
	logic           found_q, row_active_q, dict_seen_q;

	logic [KLW-1:0] key_len_n;
	logic           key_ovf_n, key_closed_n;
	logic [23:0]    recent_n;
	logic [PW-1:0]  pos_n;
	phase_t         phase_n;
	logic [1:0]     held_n;
	logic           found_n, row_active_n, dict_seen_n;
	logic           kwe;
	logic [KIW-1:0] kaddr;

	logic [2:0]     li, lp;
	logic           seps_eq, enabled, win, is_sep;
	logic [31:0]    hist;
	logic [PW-1:0]  count, kd, vc, klen_ext;
	logic [7:0]     expect_b;
	logic [2:0]     h0, hsel, hraw, hfin, held_p1;
	logic [3:1]     pm;
	res_t           res;

	always_comb begin
		li = (isep_len_q > 3'(CAP)) ? 3'(CAP) : isep_len_q;
		lp = (psep_len_q > 3'(CAP)) ? 3'(CAP) : psep_len_q;
		hist = {recent_q, data_byte};
		seps_eq = (li == lp);
		win = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < li && byte_at(isep_q, 2'(i)) != byte_at(psep_q, 2'(i)))
				seps_eq = 1'b0;
			if (3'(i) < li && byte_at(isep_q, 2'(i)) != byte_at(hist, 2'(li - 3'(i) - 3'd1)))
				win = 1'b0;
		end
		pm = '1;
		for (int h = 1; h < 4; h++)
			for (int i = 0; i < h; i++)
				if (byte_at(isep_q, 2'(i)) != byte_at(hist, 2'(h - 1 - i)))
					pm[h] = 1'b0;
		enabled = (key_len_q != '0) && !key_ovf_q && (li != 3'd0) && (lp != 3'd0) && !seps_eq;
		klen_ext = PW'(key_len_q);
		count = pos_q + PW'(1);
		kd = klen_ext + PW'(lp);
		vc = (count > kd) ? count - kd : '0;
		is_sep = (count >= PW'(li)) && win;
		expect_b = (pos_q < klen_ext) ? key_mem_q[pos_q[KIW-1:0]]
			: byte_at(psep_q, 2'(pos_q - klen_ext));
		h0 = (vc < PW'(li - 3'd1)) ? 3'(vc) : li - 3'd1;
		hsel = 3'd0;
		for (int h = 1; h < 4; h++)
			if (3'(h) <= h0 && pm[h])
				hsel = 3'(h);
		hraw = (vc + PW'(1) < PW'(li)) ? 3'(vc) : hsel;
		held_p1 = {1'b0, held_q} + 3'd1;
		hfin = (hraw > held_p1) ? held_p1 : hraw;

		key_len_n = key_len_q;
		key_ovf_n = key_ovf_q;
		key_closed_n = key_closed_q;
		recent_n = recent_q;
		pos_n = pos_q;
		phase_n = phase_q;
		held_n = held_q;
		found_n = found_q;
		row_active_n = row_active_q;
		dict_seen_n = dict_seen_q;
		kwe = 1'b0;
		kaddr = '0;
		res.src = hist;
		res.hi = 3'd0;
		res.lo = 3'd1;
		res.has_status = is_final;
		res.status = ST_NULL;
		push = 1'b0;

		if (acc && opcode == OP_KEY) begin
			if (!row_active_q) begin
				if (key_closed_q) begin
					key_len_n = '0;
					key_ovf_n = 1'b0;
					key_closed_n = 1'b0;
				end
				if (!no_byte) begin
					if (key_len_n < KLW'(KEY_MAX)) begin
						kwe = 1'b1;
						kaddr = key_len_n[KIW-1:0];
						key_len_n = key_len_n + KLW'(1);
					end else begin
						key_ovf_n = 1'b1;
					end
				end
				if (is_final)
					key_closed_n = 1'b1;
			end
		end else if (acc) begin
			if (!no_byte) begin
				dict_seen_n = 1'b1;
				recent_n = hist[23:0];
				if (enabled && phase_q != PH_DONE) begin
					if (is_sep) begin
						if (phase_q == PH_VALUE && count - PW'(li) >= kd) begin
							phase_n = PH_DONE;
							found_n = 1'b1;
						end else begin
							phase_n = PH_PREFIX;
						end
						pos_n = '0;
						held_n = 2'd0;
					end else begin
						pos_n = (count > PW'(POS_CAP)) ? PW'(POS_CAP) : count;
						case (phase_q)
							PH_PREFIX: begin
								if (pos_q >= kd || data_byte != expect_b)
									phase_n = PH_SKIP;
								else if (count == kd) begin
									phase_n = PH_VALUE;
									held_n = 2'd0;
								end
							end
							PH_VALUE: begin
								res.hi = held_p1;
								res.lo = is_final ? 3'd1 : hfin + 3'd1;
								held_n = 2'(hfin);
							end
							default: ;
						endcase
					end
				end
			end else if (is_final && enabled && phase_q == PH_VALUE) begin
				res.src = {8'h00, recent_q};
				res.hi = {1'b0, held_q};
			end
			if (is_final && enabled && phase_n == PH_VALUE)
				found_n = 1'b1;
			if (key_len_q == '0 || !dict_seen_n || li == 3'd0 || lp == 3'd0)
				res.status = ST_NULL;
			else if (seps_eq || key_ovf_q)
				res.status = ST_INVALID;
			else
				res.status = found_n ? ST_FOUND : ST_NULL;
			push = is_final || (res.hi >= res.lo);
			if (is_final) begin
				recent_n = '0;
				pos_n = '0;
				phase_n = PH_PREFIX;
				held_n = 2'd0;
				found_n = 1'b0;
				row_active_n = 1'b0;
				dict_seen_n = 1'b0;
				key_len_n = '0;
				key_ovf_n = 1'b0;
				key_closed_n = 1'b0;
			end else begin
				row_active_n = 1'b1;
			end
		end
		push_data = res;
	end

	always_ff @(posedge clk) begin
		if (kwe)
			key_mem_q[kaddr] <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isep_q <= 32'h3B;
			isep_len_q <= 3'd1;
			psep_q <= 32'h3A;
			psep_len_q <= 3'd1;
			key_len_q <= '0;
			key_ovf_q <= 1'b0;
			key_closed_q <= 1'b0;
			recent_q <= '0;
			pos_q <= '0;
			phase_q <= PH_PREFIX;
			held_q <= 2'd0;
			found_q <= 1'b0;
			row_active_q <= 1'b0;
			dict_seen_q <= 1'b0;
		end else begin
			key_len_q <= key_len_n;
			key_ovf_q <= key_ovf_n;
			key_closed_q <= key_closed_n;
			recent_q <= recent_n;
			pos_q <= pos_n;
			phase_q <= phase_n;
			held_q <= held_n;
			found_q <= found_n;
			row_active_q <= row_active_n;
			dict_seen_q <= dict_seen_n;
			if (cfg_we && !row_active_q) begin
				case (cfg_index)
					REG_ISEP:     isep_q <= cfg_data;
					REG_ISEP_LEN: isep_len_q <= cfg_data[2:0];
					REG_PSEP:     psep_q <= cfg_data;
					REG_PSEP_LEN: psep_len_q <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- rtl/core/kvse_fifo.sv -----
// Short queue of result bundles between front and back.
module kvse_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kvse_pkg::res_t wdata,
	input  logic           pop,
	output kvse_pkg::res_t rdata,
	output logic           empty,
	output logic           full
);
	import kvse_pkg::*;

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	res_t          mem_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(QDEPTH));
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)
				rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

// ----- rtl/core/kvse_back.sv -----
// Back part: unpacks result bundles into single output transfers.
module kvse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  kvse_pkg::res_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kind,
	output logic [7:0]     value_byte,
	output logic [1:0]     status,
	output logic           run_end
);
	import kvse_pkg::*;

	res_t       cur_q;
	logic [2:0] a_q;
	logic       busy_q;
	logic       is_stat, last, adv;

	always_comb begin
		is_stat = (a_q < cur_q.lo);
		last = is_stat || (a_q == cur_q.lo && !cur_q.has_status);
		kind = is_stat ? KIND_STATUS : KIND_VALUE;
		value_byte = is_stat ? 8'h00 : byte_at(cur_q.src, 2'(a_q - 3'd1));
		status = is_stat ? cur_q.status : ST_FOUND;
		run_end = last;
		out_valid = busy_q;
		adv = busy_q && out_ready;
		pop = !empty && (!busy_q || (adv && last));
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			a_q <= 3'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			a_q <= head.hi;
		end else if (adv) begin
			if (last)
				busy_q <= 1'b0;
			else
				a_q <= a_q - 3'd1;
		end
	end

endmodule

// ----- rtl/core/key_value_string_extractor_top.sv -----
// Top level of the key/value string extractor.
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_ready   | opcode, data_byte, is_final, no_byte
//  out     | out       | out_valid / out_ready | kind, value_byte, status, run_end
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
// One input item per cycle through the front; each item leaves 0 to 5 results.
// The back sends one result per cycle while out_ready is high, one item at a time;
// the two-entry bundle queue absorbs bursts, in_ready drops only when it is full.
// Reset clears all control state and loads the default separators ';' and ':'.
// Config writes are always taken (cfg_ready is high) and dropped mid-row.
module key_value_string_extractor_top #(
	parameter int KEY_MAX   = kvse_pkg::KEY_MAX_DEF,
	parameter int DELIM_MAX = kvse_pkg::DELIM_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	input  logic        is_final,
	input  logic        no_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  value_byte,
	output logic [1:0]  status,
	output logic        run_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import kvse_pkg::*;

	logic acc, push, pop, empty, full;
	res_t push_data, head;

	assign in_ready  = !full;
	assign acc       = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	kvse_front #(.KEY_MAX(KEY_MAX), .DELIM_MAX(DELIM_MAX)) u_front (
		.clk, .arst_n, .acc, .opcode, .data_byte, .is_final, .no_byte,
		.cfg_we(cfg_valid), .cfg_index, .cfg_data, .push, .push_data
	);

	kvse_fifo u_fifo (
		.clk, .arst_n, .push, .wdata(push_data), .pop, .rdata(head), .empty, .full
	);

	kvse_back u_back (
		.clk, .arst_n, .head, .empty, .pop, .out_valid, .out_ready,
		.kind, .value_byte, .status, .run_end
	);

endmodule

// ----- sim/key_value_string_extractor_top_test.sv -----
// Self-checking testbench for the key/value string extractor: directed and random rows.
`timescale 1ns / 100ps

module key_value_string_extractor_top_test;
	import kvse_pkg::*;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
		logic       fin;
		logic       nob;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] vbyte;
		logic [1:0] st;
		logic       last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = 1'b0;
	logic [7:0] data_byte = 8'd0;
	logic is_final = 1'b0;
	logic no_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [7:0] value_byte;
	logic [1:0] status;
	logic run_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'd0;

	key_value_string_extractor_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] isep, psep;
	logic [2:0] isep_len, psep_len;
	logic [7:0] key_mem [0:31];
	int key_len, item_pos, held;
	bit key_ovf, key_done, row_open, saw_dict, found;
	logic [23:0] recent;
	phase_t ph;

	item_t pending_items[$];
	result_t expected_results[$];
	int errors = 0;
	int sender_idle = 0, receiver_idle = 0;
	int hold_off = 0;
	int items_sent = 0, results_seen = 0, rows_done = 0;
	longint cycles = 0;
	bit in_taken = 1'b0;

	function automatic int eff(input logic [2:0] r);
		return (r > 4) ? 4 : int'(r);
	endfunction

	function automatic logic [7:0] byte_of(input logic [31:0] w, input int i);
		return w[8*(i%4) +: 8];
	endfunction

	function automatic bit sep_tail(input logic [31:0] h, input logic [31:0] s, input int n);
		for (int i = 0; i < n; i++)
			if (byte_of(s, i) != byte_of(h, n - 1 - i)) return 0;
		return 1;
	endfunction

	function automatic int partial_sep(input logic [31:0] h, input logic [31:0] s,
			input int n, input int lim);
		int k;
		k = n > 0 ? n - 1 : 0;
		if (lim < k) k = lim;
		for (; k > 0; k--)
			if (sep_tail(h, s, k)) return k;
		return 0;
	endfunction

	task automatic push_value(input logic [7:0] b);
		expected_results.push_back('{KIND_VALUE, b, ST_FOUND, 1'b0});
	endtask

	task automatic clear_row();
		recent = '0; item_pos = 0; ph = PH_PREFIX; held = 0; found = 0;
		row_open = 0; saw_dict = 0; key_len = 0; key_ovf = 0; key_done = 0;
	endtask

	task automatic predict_config(input logic [2:0] idx, input logic [31:0] d);
		if (row_open) return;
		case (idx)
			REG_ISEP:     isep = d;
			REG_ISEP_LEN: isep_len = d[2:0];
			REG_PSEP:     psep = d;
			REG_PSEP_LEN: psep_len = d[2:0];
			default: ;
		endcase
	endtask

	task automatic predict_item(input item_t it);
		int li, lp, n0, kd, pos, cnt, vc, h;
		bit same, en;
		logic [31:0] hist;
		logic [7:0] want;
		logic [1:0] st;
		li = eff(isep_len); lp = eff(psep_len);
		n0 = expected_results.size();
		if (it.op == OP_KEY) begin
			if (row_open) return;
			if (key_done) begin
				key_len = 0; key_ovf = 0; key_done = 0;
			end
			if (!it.nob) begin
				if (key_len < 32) key_mem[key_len++] = it.data;
				else key_ovf = 1;
			end
			if (it.fin) key_done = 1;
			return;
		end
		same = (li == lp);
		for (int i = 0; i < li && same; i++)
			if (byte_of(isep, i) != byte_of(psep, i)) same = 0;
		en = key_len > 0 && !key_ovf && li > 0 && lp > 0 && !same;
		if (!it.nob) begin
			hist = {recent, it.data};
			saw_dict = 1;
			recent = hist[23:0];
			if (en && ph != PH_DONE) begin
				pos = item_pos; cnt = pos + 1; kd = key_len + lp;
				if (cnt >= li && sep_tail(hist, isep, li)) begin
					if (ph == PH_VALUE && cnt - li >= kd) begin
						ph = PH_DONE; found = 1;
					end else ph = PH_PREFIX;
					item_pos = 0; held = 0;
				end else begin
					item_pos = cnt > 44 ? 44 : cnt;
					if (ph == PH_PREFIX) begin
						want = pos < key_len ? key_mem[pos % 32] : byte_of(psep, pos - key_len);
						if (pos >= kd || it.data != want) ph = PH_SKIP;
						else if (cnt == kd) begin
							ph = PH_VALUE; held = 0;
						end
					end else if (ph == PH_VALUE) begin
						vc = cnt > kd ? cnt - kd : 0;
						h = (vc + 1 < li) ? vc : partial_sep(hist, isep, li, vc);
						if (h > held + 1) h = held + 1;
						for (int a = held + 1; a > h; a--) push_value(byte_of(hist, a - 1));
						held = h;
					end
				end
			end
		end
		if (it.fin) begin
			if (en && ph == PH_VALUE) begin
				for (int a = held; a > 0; a--) push_value(byte_of({8'd0, recent}, a - 1));
				found = 1;
			end
			if (key_len == 0 || !saw_dict || li == 0 || lp == 0) st = ST_NULL;
			else if (same || key_ovf) st = ST_INVALID;
			else st = found ? ST_FOUND : ST_NULL;
			expected_results.push_back('{KIND_STATUS, 8'd0, st, 1'b0});
			clear_row();
		end else row_open = 1;
		if (expected_results.size() > n0)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	// sender; a new item is offered only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (in_taken || !in_valid)) begin
			in_taken = 1'b0;
			if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle) begin
				in_valid <= 1'b1;
				{opcode, data_byte, is_final, no_byte} <= pending_items[0];
			end else in_valid <= 1'b0;
		end
	end

	// receiver; a nonzero hold_off counts down a long stall
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else out_ready <= $urandom_range(99) >= receiver_idle;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("Test completed with failures");
			$finish;
		end
		if (arst_n && in_valid && in_ready) begin
			predict_item(pending_items.pop_front());
			items_sent++;
			in_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind=%b byte=%h status=%0d end=%b",
					$time, kind, value_byte, status, run_end);
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (e.kind == KIND_STATUS) rows_done++;
				if (e != result_t'{kind, value_byte, status, run_end}) begin
					errors++;
					$display("%0t: mismatch expected kind=%b byte=%h status=%0d end=%b, got kind=%b byte=%h status=%0d end=%b",
						$time, e.kind, e.vbyte, e.st, e.last, kind, value_byte, status, run_end);
				end
			end
		end
	end

	task automatic add(input logic op, input logic [7:0] d, input logic fin, input logic nob);
		pending_items.push_back('{op, d, fin, nob});
	endtask

	task automatic add_str(input logic op, input string s);
		for (int i = 0; i < s.len(); i++) add(op, s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		predict_config(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte(input logic [31:0] s, input logic [31:0] p);
		case ($urandom_range(5))
			0: return byte_of(s, $urandom_range(3));
			1: return byte_of(p, $urandom_range(3));
			2: return 8'($urandom);
			default: return 8'($urandom_range(97, 100));
		endcase
	endfunction

	// mostly well-formed rows: key, then items with some matching the key
	task automatic random_row();
		logic [7:0] k[$];
		int kl, ni, li, lp;
		li = eff(isep_len); lp = eff(psep_len);
		kl = ($urandom_range(19) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 3);
		if (kl == 0) add(OP_KEY, 8'($urandom), 1'b1, 1'b1);
		for (int i = 0; i < kl; i++) begin
			k.push_back(8'($urandom_range(97, 99)));
			add(OP_KEY, k[i], i == kl - 1, 1'b0);
		end
		ni = $urandom_range(0, 3);
		if (ni == 0) begin
			add(OP_DICT, 8'($urandom), 1'b1, 1'b1);
			return;
		end
		for (int j = 0; j < ni; j++) begin
			if ($urandom_range(3) != 0)
				foreach (k[i]) add(OP_DICT, ($urandom_range(9) == 0) ? 8'($urandom) : k[i], 0, 0);
			if ($urandom_range(4) != 0)
				for (int i = 0; i < lp; i++) add(OP_DICT, byte_of(psep, i), 0, 0);
			repeat ($urandom_range(0, 4)) add(OP_DICT, pick_byte(isep, psep), 0, 0);
			if (j < ni - 1)
				for (int i = 0; i < li; i++) add(OP_DICT, byte_of(isep, i), 0, 0);
			if ($urandom_range(15) == 0) add(OP_DICT, 8'($urandom), 0, 1'b1);
		end
		add(OP_DICT, pick_byte(isep, psep), 1'b1, 1'b0);
		if ($urandom_range(9) == 0) add(OP_KEY, 8'($urandom), 1'b0, 1'b0);
	endtask

	initial begin
		isep = 32'h3B; isep_len = 3'd1; psep = 32'h3A; psep_len = 3'd1;
		clear_row();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: basic find, empty value, no match, empty key/dict, key overflow, noise
		add_str(OP_KEY, "k2"); add_str(OP_DICT, "k1:v1;;k2:v2");
		add_str(OP_KEY, "a");  add_str(OP_DICT, ";a:;b:x");
		add_str(OP_KEY, "z");  add_str(OP_DICT, "a:1");
		add(OP_KEY, 8'hFF, 1'b1, 1'b1); add_str(OP_DICT, "a:1");
		add_str(OP_KEY, "a");  add(OP_DICT, 8'h00, 1'b1, 1'b1);
		for (int i = 0; i < 33; i++) add(OP_KEY, 8'h61, i == 32, 1'b0);
		add_str(OP_DICT, "a:");
		add(OP_KEY, 8'h00, 1'b1, 1'b0); add(OP_DICT, 8'hFF, 1'b0, 1'b1);
		add(OP_DICT, 8'h00, 1'b0, 1'b0); add(OP_DICT, 8'h3A, 1'b0, 1'b0);
		add(OP_DICT, 8'hFF, 1'b1, 1'b0);
		drain();

		for (int phase_no = 0; phase_no < 6; phase_no++) begin
			case (phase_no)
				0: begin write_reg(REG_ISEP, 32'hFF3B3B00); write_reg(REG_ISEP_LEN, 3'd4);
					write_reg(REG_PSEP, 32'h0000FF3A); write_reg(REG_PSEP_LEN, 3'd2); end
				1: begin write_reg(REG_ISEP, 32'h61616161); write_reg(REG_ISEP_LEN, 3'd2);
					write_reg(REG_PSEP, 32'hFFFFFFFF); write_reg(REG_PSEP_LEN, 3'd7); end
				2: begin write_reg(REG_ISEP, 32'h3A); write_reg(REG_ISEP_LEN, 3'd1);
					write_reg(REG_PSEP, 32'h3A); write_reg(REG_PSEP_LEN, 3'd1); end
				3: begin write_reg(REG_ISEP, 32'h3B3B3B); write_reg(REG_ISEP_LEN, 3'd3);
					write_reg(REG_PSEP, 32'h3D); write_reg(REG_PSEP_LEN, 3'd0); end
				4: begin write_reg(REG_ISEP, 32'h3B); write_reg(REG_PSEP, 32'h3A3A3A);
					write_reg(REG_PSEP_LEN, 3'd3); write_reg(3'd5, 32'h1); end
				default: begin write_reg(REG_ISEP, 32'h3B); write_reg(REG_ISEP_LEN, 3'd1);
					write_reg(REG_PSEP, 32'h3A); write_reg(REG_PSEP_LEN, 3'd1); end
			endcase
			sender_idle = (phase_no < 2) ? 23 : (phase_no < 4) ? 59 : 0;
			receiver_idle = (phase_no < 2) ? 59 : (phase_no < 4) ? 23 : 0;
			while (pending_items.size() < 65) random_row();
			if (phase_no == 5) hold_off = 200;
			drain();
		end

		$display("Covered %0d input transfers, %0d result transfers, %0d rows over six separator settings.",
			items_sent, results_seen, rows_done);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
